@@ design/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, codes and helpers of the subscription client state machine.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // Width of all timer and expiry values in seconds.
  localparam int unsigned TimeBits = 16;

  // Configuration port geometry.
  localparam int unsigned CfgAddrBits = 5;
  localparam int unsigned CfgDataBits = 32;

  // Packed widths of the stream words.
  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 56;

  // Subscription states, one-hot inside the block.
  typedef enum logic [8:0] {
    StUnconf        = 9'b000000001,
    StUnconfDestroy = 9'b000000010,
    StConfirmed     = 9'b000000100,
    StWaiting       = 9'b000001000,
    StResub         = 9'b000010000,
    StResubDestroy  = 9'b000100000,
    StWaitTerm      = 9'b001000000,
    StPredestroyed  = 9'b010000000,
    StDestroyed     = 9'b100000000
  } state_e;

  // External numbering of the states on the result word.
  typedef enum logic [3:0] {
    CodeUnconf        = 4'd0,
    CodeUnconfDestroy = 4'd1,
    CodeConfirmed     = 4'd2,
    CodeWaiting       = 4'd3,
    CodeResub         = 4'd4,
    CodeResubDestroy  = 4'd5,
    CodeWaitTerm      = 4'd6,
    CodePredestroyed  = 4'd7,
    CodeDestroyed     = 4'd8
  } state_code_e;

  // Input event kinds.
  typedef enum logic [2:0] {
    EvNotify  = 3'd0,
    Ev1xx     = 3'd1,
    Ev2xx     = 3'd2,
    Ev3xx     = 3'd3,
    Ev4xx     = 3'd4,
    EvTick    = 3'd5,
    EvDestroy = 3'd6,
    EvStart   = 3'd7
  } event_e;

  typedef enum logic [2:0] {
    SendNone    = 3'd0,
    SendTarget  = 3'd1,
    SendContact = 3'd2,
    SendRefresh = 3'd3,
    SendUnsub   = 3'd4
  } send_e;

  typedef enum logic [1:0] {
    TmrKeep = 2'd0,
    TmrStop = 2'd1,
    TmrLoad = 2'd2
  } tmr_e;

  typedef enum logic [2:0] {
    DlgNone        = 3'd0,
    DlgRefresh     = 3'd1,
    DlgConfirm     = 3'd2,
    DlgDropUnconf  = 3'd3,
    DlgDropConf    = 3'd4,
    DlgConfirmDrop = 3'd5
  } dlg_e;

  // Notification handling, rejects carry the response code in the name.
  typedef enum logic [2:0] {
    NtfNone    = 3'd0,
    NtfDeliver = 3'd1,
    NtfRej200  = 3'd2,
    NtfRej481  = 3'd3,
    NtfRej500  = 3'd4
  } ntf_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    CfgRefreshMargin = 3'd0,
    CfgMinRefresh    = 3'd1,
    CfgRetryAfterErr = 3'd2,
    CfgTermWait      = 3'd3,
    CfgSubLength     = 3'd4
  } cfg_idx_e;

  // Current configuration values.
  typedef struct packed {
    logic [TimeBits-1:0] refresh_margin;
    logic [TimeBits-1:0] min_refresh_time;
    logic [TimeBits-1:0] retry_after_error;
    logic [TimeBits-1:0] term_notify_wait;
    logic [TimeBits-1:0] subscription_length;
  } cfg_t;

  // One decoded event.
  typedef struct packed {
    event_e              mode;
    logic [TimeBits-1:0] expires_seconds;
    logic                contact_present;
    logic                notify_terminating;
    logic                send_fails;
  } event_t;

  // One result of the transition logic.
  typedef struct packed {
    state_e              st;
    send_e               send;
    logic [TimeBits-1:0] sexp;
    tmr_e                tcmd;
    logic [TimeBits-1:0] tval;
    dlg_e                dlg;
    ntf_e                ntf;
    logic                rel;
    logic                fre;
    logic                err;
    logic                unx;
  } result_t;

  // Map the one-hot state to its external number.
  function automatic state_code_e state_code(state_e s);
    state_code_e c;
    unique case (s)
      StUnconf:        c = CodeUnconf;
      StUnconfDestroy: c = CodeUnconfDestroy;
      StConfirmed:     c = CodeConfirmed;
      StWaiting:       c = CodeWaiting;
      StResub:         c = CodeResub;
      StResubDestroy:  c = CodeResubDestroy;
      StWaitTerm:      c = CodeWaitTerm;
      StPredestroyed:  c = CodePredestroyed;
      default:         c = CodeDestroyed;
    endcase
    return c;
  endfunction

endpackage

@@ design/ssc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ssc_cfg_regs
// Configuration register file behind a simple APB-style write/read port.
// ----------------------------------------------------------------------------
module ssc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssc_pkg::CfgAddrBits-1:0]  paddr,
  input  logic [ssc_pkg::CfgDataBits-1:0]  pwdata,
  output logic [ssc_pkg::CfgDataBits-1:0]  prdata,
  output logic                             pready,
  output ssc_pkg::cfg_t                    cfg_o
);

  ssc_pkg::cfg_t            cfg_q;
  ssc_pkg::cfg_idx_e        idx;
  logic                     wr_en;
  logic [ssc_pkg::TimeBits-1:0] wdata;
  logic [ssc_pkg::TimeBits-1:0] rdata;

  assign pready = 1'b1;
  assign idx    = ssc_pkg::cfg_idx_e'(paddr[ssc_pkg::CfgAddrBits-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign wdata  = pwdata[ssc_pkg::TimeBits-1:0];

  // Register writes; addresses past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.refresh_margin      <= ssc_pkg::TimeBits'(30);
      cfg_q.min_refresh_time    <= ssc_pkg::TimeBits'(30);
      cfg_q.retry_after_error   <= ssc_pkg::TimeBits'(120);
      cfg_q.term_notify_wait    <= ssc_pkg::TimeBits'(30);
      cfg_q.subscription_length <= ssc_pkg::TimeBits'(3600);
    end else if (wr_en) begin
      unique case (idx)
        ssc_pkg::CfgRefreshMargin: cfg_q.refresh_margin      <= wdata;
        ssc_pkg::CfgMinRefresh:    cfg_q.min_refresh_time    <= wdata;
        ssc_pkg::CfgRetryAfterErr: cfg_q.retry_after_error   <= wdata;
        ssc_pkg::CfgTermWait:      cfg_q.term_notify_wait    <= wdata;
        ssc_pkg::CfgSubLength:     cfg_q.subscription_length <= wdata;
        default: ;
      endcase
    end
  end

  // Read back of the addressed register.
  always_comb begin
    unique case (idx)
      ssc_pkg::CfgRefreshMargin: rdata = cfg_q.refresh_margin;
      ssc_pkg::CfgMinRefresh:    rdata = cfg_q.min_refresh_time;
      ssc_pkg::CfgRetryAfterErr: rdata = cfg_q.retry_after_error;
      ssc_pkg::CfgTermWait:      rdata = cfg_q.term_notify_wait;
      ssc_pkg::CfgSubLength:     rdata = cfg_q.subscription_length;
      default:                   rdata = '0;
    endcase
  end

  assign prdata = ssc_pkg::CfgDataBits'(rdata);
  assign cfg_o  = cfg_q;

endmodule

@@ design/ssc_next.sv @@
// ----------------------------------------------------------------------------
// ssc_next
// Transition logic: one event and the current state give the next state and
// all action commands.
// ----------------------------------------------------------------------------
module ssc_next (
  input  ssc_pkg::state_e  state_i,
  input  ssc_pkg::event_t  ev_i,
  input  ssc_pkg::cfg_t    cfg_i,
  output ssc_pkg::result_t res_o
);

  logic [ssc_pkg::TimeBits:0]   diff;
  logic [ssc_pkg::TimeBits-1:0] refresh_val;
  logic                         is_resp;
  logic                         fails;
  logic                         term;
  ssc_pkg::result_t             r;

  // Refresh load: expiry less the margin, clamped up to the minimum.
  assign diff = {1'b0, ev_i.expires_seconds} - {1'b0, cfg_i.refresh_margin};
  assign refresh_val = (diff[ssc_pkg::TimeBits] ||
                        (diff[ssc_pkg::TimeBits-1:0] < cfg_i.min_refresh_time)) ?
                       cfg_i.min_refresh_time : diff[ssc_pkg::TimeBits-1:0];

  assign is_resp = (ev_i.mode == ssc_pkg::Ev1xx) || (ev_i.mode == ssc_pkg::Ev2xx) ||
                   (ev_i.mode == ssc_pkg::Ev3xx) || (ev_i.mode == ssc_pkg::Ev4xx);
  assign fails   = ev_i.send_fails;
  assign term    = ev_i.notify_terminating;

  // Per-state transition table.
  always_comb begin
    r      = '0;
    r.st   = state_i;
    r.send = ssc_pkg::SendNone;
    r.tcmd = ssc_pkg::TmrKeep;
    r.dlg  = ssc_pkg::DlgNone;
    r.ntf  = ssc_pkg::NtfNone;

    if (ev_i.mode == ssc_pkg::EvStart) begin
      if (state_i == ssc_pkg::StDestroyed) begin
        r.st   = ssc_pkg::StUnconf;
        r.send = ssc_pkg::SendTarget;
        if (fails) begin
          r.st   = ssc_pkg::StWaiting;
          r.tcmd = ssc_pkg::TmrLoad;
          r.tval = cfg_i.retry_after_error;
        end
      end else begin
        r.unx = 1'b1;
      end
    end else begin
      unique case (state_i)
        ssc_pkg::StUnconf, ssc_pkg::StResub: begin
          priority case (ev_i.mode)
            ssc_pkg::EvNotify: begin
              r.dlg = ssc_pkg::DlgRefresh;
              r.ntf = ssc_pkg::NtfDeliver;
            end
            ssc_pkg::Ev2xx: begin
              r.st   = ssc_pkg::StConfirmed;
              r.dlg  = (state_i == ssc_pkg::StUnconf) ? ssc_pkg::DlgConfirm :
                                                        ssc_pkg::DlgRefresh;
              r.tcmd = ssc_pkg::TmrLoad;
              r.tval = refresh_val;
              r.rel  = 1'b1;
            end
            ssc_pkg::Ev3xx: begin
              // Redirect: retry at the contact, or fall back to error wait.
              r.rel  = 1'b1;
              r.tcmd = ssc_pkg::TmrStop;
              r.dlg  = (state_i == ssc_pkg::StUnconf) ? ssc_pkg::DlgDropUnconf :
                                                        ssc_pkg::DlgDropConf;
              if (ev_i.contact_present && !fails) begin
                r.st   = ssc_pkg::StUnconf;
                r.send = ssc_pkg::SendContact;
              end else begin
                if (ev_i.contact_present) r.send = ssc_pkg::SendContact;
                r.st   = ssc_pkg::StWaiting;
                r.err  = 1'b1;
                r.tcmd = ssc_pkg::TmrLoad;
                r.tval = cfg_i.retry_after_error;
              end
            end
            ssc_pkg::Ev4xx, ssc_pkg::EvTick: begin
              r.dlg  = (state_i == ssc_pkg::StUnconf) ? ssc_pkg::DlgDropUnconf :
                                                        ssc_pkg::DlgDropConf;
              r.rel  = 1'b1;
              r.st   = ssc_pkg::StWaiting;
              r.err  = 1'b1;
              r.tcmd = ssc_pkg::TmrLoad;
              r.tval = cfg_i.retry_after_error;
            end
            ssc_pkg::EvDestroy: begin
              r.st = (state_i == ssc_pkg::StUnconf) ? ssc_pkg::StUnconfDestroy :
                                                      ssc_pkg::StResubDestroy;
            end
            default: ;
          endcase
        end

        ssc_pkg::StUnconfDestroy, ssc_pkg::StResubDestroy: begin
          priority case (ev_i.mode)
            ssc_pkg::EvNotify: begin
              r.dlg = ssc_pkg::DlgRefresh;
              r.ntf = ssc_pkg::NtfRej200;
            end
            ssc_pkg::Ev2xx: begin
              // Accepted while a destroy waits: unsubscribe at once.
              r.rel  = 1'b1;
              r.tcmd = ssc_pkg::TmrStop;
              r.st   = ssc_pkg::StPredestroyed;
              r.send = ssc_pkg::SendUnsub;
              if (state_i == ssc_pkg::StUnconfDestroy) r.dlg = ssc_pkg::DlgConfirm;
              if (fails) begin
                r.st  = ssc_pkg::StDestroyed;
                r.fre = 1'b1;
                r.dlg = (state_i == ssc_pkg::StUnconfDestroy) ?
                        ssc_pkg::DlgConfirmDrop : ssc_pkg::DlgDropConf;
              end
            end
            ssc_pkg::Ev3xx, ssc_pkg::Ev4xx, ssc_pkg::EvTick: begin
              r.rel  = 1'b1;
              r.tcmd = ssc_pkg::TmrStop;
              r.st   = ssc_pkg::StDestroyed;
              r.fre  = 1'b1;
              r.dlg  = (state_i == ssc_pkg::StUnconfDestroy) ?
                       ssc_pkg::DlgDropUnconf : ssc_pkg::DlgDropConf;
            end
            default: ;
          endcase
        end

        ssc_pkg::StConfirmed: begin
          if (is_resp) begin
            r.unx = 1'b1;
            r.rel = (ev_i.mode != ssc_pkg::Ev1xx);
          end else if (ev_i.mode == ssc_pkg::EvNotify) begin
            r.dlg = ssc_pkg::DlgRefresh;
            r.ntf = ssc_pkg::NtfDeliver;
          end else if (ev_i.mode == ssc_pkg::EvDestroy) begin
            r.tcmd = ssc_pkg::TmrStop;
            r.st   = ssc_pkg::StPredestroyed;
            r.send = ssc_pkg::SendUnsub;
            if (fails) begin
              r.st  = ssc_pkg::StDestroyed;
              r.dlg = ssc_pkg::DlgDropConf;
              r.fre = 1'b1;
            end
          end else if (ev_i.mode == ssc_pkg::EvTick) begin
            r.st   = ssc_pkg::StResub;
            r.send = ssc_pkg::SendRefresh;
            r.sexp = cfg_i.subscription_length;
            if (fails) begin
              r.dlg  = ssc_pkg::DlgDropConf;
              r.st   = ssc_pkg::StWaiting;
              r.err  = 1'b1;
              r.tcmd = ssc_pkg::TmrLoad;
              r.tval = cfg_i.retry_after_error;
            end
          end
        end

        ssc_pkg::StWaiting: begin
          if (is_resp) begin
            r.unx = 1'b1;
            r.rel = (ev_i.mode != ssc_pkg::Ev1xx);
          end else if (ev_i.mode == ssc_pkg::EvNotify) begin
            r.ntf = ssc_pkg::NtfRej500;
            r.unx = 1'b1;
          end else if (ev_i.mode == ssc_pkg::EvDestroy) begin
            r.tcmd = ssc_pkg::TmrStop;
            r.st   = ssc_pkg::StDestroyed;
            r.fre  = 1'b1;
          end else if (ev_i.mode == ssc_pkg::EvTick) begin
            r.st   = ssc_pkg::StUnconf;
            r.send = ssc_pkg::SendTarget;
            if (fails) begin
              r.st   = ssc_pkg::StWaiting;
              r.tcmd = ssc_pkg::TmrLoad;
              r.tval = cfg_i.retry_after_error;
            end
          end
        end

        ssc_pkg::StWaitTerm: begin
          if (is_resp) begin
            r.unx = 1'b1;
            r.rel = (ev_i.mode != ssc_pkg::Ev1xx);
          end else if (ev_i.mode == ssc_pkg::EvNotify) begin
            r.ntf = ssc_pkg::NtfRej200;
            if (term) begin
              r.tcmd = ssc_pkg::TmrStop;
              r.st   = ssc_pkg::StDestroyed;
              r.dlg  = ssc_pkg::DlgDropConf;
              r.fre  = 1'b1;
            end
          end else if (ev_i.mode == ssc_pkg::EvTick) begin
            r.st  = ssc_pkg::StDestroyed;
            r.dlg = ssc_pkg::DlgDropConf;
            r.fre = 1'b1;
          end
        end

        ssc_pkg::StPredestroyed: begin
          priority case (ev_i.mode)
            ssc_pkg::EvNotify: begin
              r.dlg = ssc_pkg::DlgRefresh;
              r.ntf = ssc_pkg::NtfRej200;
              if (term) begin
                r.tcmd = ssc_pkg::TmrStop;
                r.st   = ssc_pkg::StDestroyed;
                r.dlg  = ssc_pkg::DlgDropConf;
                r.fre  = 1'b1;
              end
            end
            ssc_pkg::Ev2xx: begin
              r.st   = ssc_pkg::StWaitTerm;
              r.tcmd = ssc_pkg::TmrLoad;
              r.tval = cfg_i.term_notify_wait;
              r.rel  = 1'b1;
            end
            ssc_pkg::Ev3xx, ssc_pkg::Ev4xx, ssc_pkg::EvTick: begin
              r.tcmd = ssc_pkg::TmrStop;
              r.rel  = 1'b1;
              r.st   = ssc_pkg::StDestroyed;
              r.dlg  = ssc_pkg::DlgDropConf;
              r.fre  = 1'b1;
            end
            default: ;
          endcase
        end

        // Destroyed, and any state code that should never occur.
        default: begin
          r.st = ssc_pkg::StDestroyed;
          priority case (ev_i.mode)
            ssc_pkg::EvNotify:                              r.ntf = ssc_pkg::NtfRej481;
            ssc_pkg::Ev2xx, ssc_pkg::Ev3xx, ssc_pkg::Ev4xx: r.rel = 1'b1;
            ssc_pkg::Ev1xx, ssc_pkg::EvTick:                r.unx = 1'b1;
            default: ;
          endcase
        end
      endcase
    end
  end

  assign res_o = r;

endmodule

@@ design/sip_subscription_client_fsm_top.sv @@
// ----------------------------------------------------------------------------
// sip_subscription_client_fsm_top
// Client side of one event subscription: each event word yields one result
// word with the next state and the send, timer, dialog and notify commands.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents
//  s_axis    in         tuser: mode; tdata: expires, contact, terminating, fails
//  m_axis    out        tdata: next state and all action commands
//  apb       in/out     five 16-bit configuration registers at 4-byte steps
//
// One event word is taken every cycle while the result side is not stalled. A
// word is held in the input register, then the transition logic updates the
// state register and fills the result register, from which the result word is read.
// The input register advances whenever the result register is empty or
// drained in the same cycle, so a stalled output backs up at most one word.
// Reset puts the subscription into the destroyed state with default timings.
module sip_subscription_client_fsm_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Event stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [15:0] expires_seconds, [16] contact_present, [17] notify_terminating,
  // [18] send_fails, [23:19] zero
  input  logic [ssc_pkg::InDataBits-1:0]     s_axis_tdata_i,
  // [2:0] mode
  input  logic [2:0]                         s_axis_tuser_i,
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [3:0] new_state, [6:4] send_kind, [22:7] send_expires, [24:23] timer_cmd,
  // [40:25] timer_value, [43:41] dialog_cmd, [46:44] notify_cmd,
  // [47] release_response_ref, [48] free_object, [49] error_notice,
  // [50] unexpected_event, [55:51] zero
  output logic [ssc_pkg::OutDataBits-1:0]    m_axis_tdata_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ssc_pkg::CfgAddrBits-1:0]    paddr,
  input  logic [ssc_pkg::CfgDataBits-1:0]    pwdata,
  output logic [ssc_pkg::CfgDataBits-1:0]    prdata,
  output logic                               pready
);

  ssc_pkg::cfg_t    cfg;
  ssc_pkg::event_t  ev_q;
  ssc_pkg::event_t  ev_d;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;
  ssc_pkg::state_e  state_q;
  ssc_pkg::result_t res;
  logic [ssc_pkg::OutDataBits-1:0] out_data_q;
  logic [ssc_pkg::OutDataBits-1:0] out_data_d;

  ssc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssc_next u_next (
    .state_i (state_q),
    .ev_i    (ev_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Handshakes: the held word moves on when the result register frees up.
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;

  // Unpack the incoming word.
  always_comb begin
    ev_d.mode               = ssc_pkg::event_e'(s_axis_tuser_i);
    ev_d.expires_seconds    = s_axis_tdata_i[ssc_pkg::TimeBits-1:0];
    ev_d.contact_present    = s_axis_tdata_i[16];
    ev_d.notify_terminating = s_axis_tdata_i[17];
    ev_d.send_fails         = s_axis_tdata_i[18];
  end

  // Pack the result word.
  always_comb begin
    out_data_d = {5'd0, res.unx, res.err, res.fre, res.rel,
                  res.ntf, res.dlg, res.tval, res.tcmd, res.sexp, res.send,
                  ssc_pkg::state_code(res.st)};
  end

  // Input and result register valid, and state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ssc_pkg::StDestroyed;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= res.st;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      ev_q <= ev_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subscription client state machine. Event words
// go in on the input stream and a local transition model predicts the result
// word of each one. Every result word is compared field by field with the
// oldest prediction. Directed events come first, then state-aware random
// traffic under several register settings, with random gaps and stalls on
// both streams and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import ssc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;

  // One predicted result word.
  typedef struct {
    state_code_e     st;
    send_e           send;
    logic [15:0]     sexp;
    tmr_e            tcmd;
    logic [15:0]     tval;
    dlg_e            dlg;
    ntf_e            ntf;
    logic            rel;
    logic            fre;
    logic            err;
    logic            unx;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [InDataBits-1:0]  s_axis_tdata_i;
  logic [2:0]             s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OutDataBits-1:0] m_axis_tdata_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata;
  logic [CfgDataBits-1:0] prdata;
  logic                   pready;

  // Local copy of the block state and registers.
  state_code_e sub_state_q;
  logic [15:0] margin_q;
  logic [15:0] min_refresh_q;
  logic [15:0] retry_q;
  logic [15:0] term_wait_q;
  logic [15:0] sub_length_q;

  outcome_t pending_outcomes[$];

  int unsigned fail_count;
  int unsigned events_sent;
  int unsigned results_checked;
  int unsigned register_writes;
  int unsigned cycle_count;
  bit          state_seen[9];

  // Idling control for both streams.
  bit src_idle_on;
  bit sink_idle_on;
  int sink_stall;
  int sink_hold;
  int hold_request;

  sip_subscription_client_fsm_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  // Run limit, in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_outcomes.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // Short gaps most of the time, now and then a long one.
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result ready: a requested hold-off wins, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      sink_hold = hold_request;
      hold_request = 0;
    end
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (sink_idle_on && $urandom_range(0, 3) == 0) sink_stall = pick_gap(1'b1);
    end
  end

  // Refresh timer load after a 2xx, clamped from below.
  function automatic logic [15:0] refresh_load(logic [15:0] expires);
    int signed e;
    e = int'(expires) - int'(margin_q);
    if (e < int'(min_refresh_q)) e = int'(min_refresh_q);
    return e[15:0];
  endfunction

  function automatic void go_error_wait(inout outcome_t r);
    r.st = CodeWaiting;
    r.err = 1'b1;
    r.tcmd = TmrLoad;
    r.tval = retry_q;
  endfunction

  function automatic void go_destroyed(inout outcome_t r, input dlg_e d);
    r.st = CodeDestroyed;
    r.dlg = d;
    r.fre = 1'b1;
  endfunction

  // Unsubscribe from a confirmed dialog; the dialog command applies on failure.
  function automatic void go_unsubscribe(inout outcome_t r, input logic fails,
                                         input dlg_e fail_dlg);
    r.st = CodePredestroyed;
    r.send = SendUnsub;
    r.sexp = '0;
    if (fails) go_destroyed(r, fail_dlg);
  endfunction

  // Transition of the subscription for one event from the current state.
  function automatic outcome_t predict_transition(event_e ev, logic [15:0] expires,
                                                  logic contact, logic term,
                                                  logic fails);
    outcome_t r;
    logic     resp;
    logic     unconf_side;
    resp = (ev >= Ev1xx) && (ev <= Ev4xx);
    unconf_side = (sub_state_q == CodeUnconf) || (sub_state_q == CodeUnconfDestroy);
    r.st = sub_state_q;
    r.send = SendNone;
    r.sexp = '0;
    r.tcmd = TmrKeep;
    r.tval = '0;
    r.dlg = DlgNone;
    r.ntf = NtfNone;
    r.rel = 1'b0;
    r.fre = 1'b0;
    r.err = 1'b0;
    r.unx = 1'b0;

    if (ev == EvStart) begin
      if (sub_state_q == CodeDestroyed) begin
        r.st = CodeUnconf;
        r.send = SendTarget;
        if (fails) begin
          r.st = CodeWaiting;
          r.tcmd = TmrLoad;
          r.tval = retry_q;
        end
      end else begin
        r.unx = 1'b1;
      end
      return r;
    end

    case (sub_state_q)
      CodeUnconf, CodeResub: begin
        case (ev)
          EvNotify: begin
            r.dlg = DlgRefresh;
            r.ntf = NtfDeliver;
          end
          Ev2xx: begin
            r.st = CodeConfirmed;
            r.dlg = unconf_side ? DlgConfirm : DlgRefresh;
            r.tcmd = TmrLoad;
            r.tval = refresh_load(expires);
            r.rel = 1'b1;
          end
          Ev3xx: begin
            r.rel = 1'b1;
            r.tcmd = TmrStop;
            r.dlg = unconf_side ? DlgDropUnconf : DlgDropConf;
            if (contact) begin
              r.st = CodeUnconf;
              r.send = SendContact;
              if (fails) go_error_wait(r);
            end else begin
              go_error_wait(r);
            end
          end
          Ev4xx, EvTick: begin
            r.dlg = unconf_side ? DlgDropUnconf : DlgDropConf;
            r.rel = 1'b1;
            go_error_wait(r);
          end
          EvDestroy: r.st = unconf_side ? CodeUnconfDestroy : CodeResubDestroy;
          default: ;
        endcase
      end
      CodeUnconfDestroy, CodeResubDestroy: begin
        case (ev)
          EvNotify: begin
            r.dlg = DlgRefresh;
            r.ntf = NtfRej200;
          end
          Ev2xx: begin
            r.rel = 1'b1;
            r.tcmd = TmrStop;
            if (unconf_side) begin
              r.dlg = DlgConfirm;
              go_unsubscribe(r, fails, DlgConfirmDrop);
            end else begin
              go_unsubscribe(r, fails, DlgDropConf);
            end
          end
          Ev3xx, Ev4xx, EvTick: begin
            r.rel = 1'b1;
            r.tcmd = TmrStop;
            go_destroyed(r, unconf_side ? DlgDropUnconf : DlgDropConf);
          end
          default: ;
        endcase
      end
      CodeConfirmed: begin
        if (resp) begin
          r.unx = 1'b1;
          r.rel = (ev != Ev1xx);
        end else if (ev == EvNotify) begin
          r.dlg = DlgRefresh;
          r.ntf = NtfDeliver;
        end else if (ev == EvDestroy) begin
          r.tcmd = TmrStop;
          go_unsubscribe(r, fails, DlgDropConf);
        end else if (ev == EvTick) begin
          r.st = CodeResub;
          r.send = SendRefresh;
          r.sexp = sub_length_q;
          if (fails) begin
            r.dlg = DlgDropConf;
            go_error_wait(r);
          end
        end
      end
      CodeWaiting: begin
        if (resp) begin
          r.unx = 1'b1;
          r.rel = (ev != Ev1xx);
        end else if (ev == EvNotify) begin
          r.ntf = NtfRej500;
          r.unx = 1'b1;
        end else if (ev == EvDestroy) begin
          r.tcmd = TmrStop;
          go_destroyed(r, DlgNone);
        end else if (ev == EvTick) begin
          r.st = CodeUnconf;
          r.send = SendTarget;
          if (fails) begin
            r.st = CodeWaiting;
            r.tcmd = TmrLoad;
            r.tval = retry_q;
          end
        end
      end
      CodeWaitTerm: begin
        if (resp) begin
          r.unx = 1'b1;
          r.rel = (ev != Ev1xx);
        end else if (ev == EvNotify) begin
          r.ntf = NtfRej200;
          if (term) begin
            r.tcmd = TmrStop;
            go_destroyed(r, DlgDropConf);
          end
        end else if (ev == EvTick) begin
          go_destroyed(r, DlgDropConf);
        end
      end
      CodePredestroyed: begin
        case (ev)
          EvNotify: begin
            r.dlg = DlgRefresh;
            r.ntf = NtfRej200;
            if (term) begin
              r.tcmd = TmrStop;
              go_destroyed(r, DlgDropConf);
            end
          end
          Ev2xx: begin
            r.st = CodeWaitTerm;
            r.tcmd = TmrLoad;
            r.tval = term_wait_q;
            r.rel = 1'b1;
          end
          Ev3xx, Ev4xx, EvTick: begin
            r.tcmd = TmrStop;
            r.rel = 1'b1;
            go_destroyed(r, DlgDropConf);
          end
          default: ;
        endcase
      end
      default: begin
        // Destroyed: only a start opens a subscription.
        if (ev == EvNotify) r.ntf = NtfRej481;
        else if (ev == Ev2xx || ev == Ev3xx || ev == Ev4xx) r.rel = 1'b1;
        else if (ev == Ev1xx || ev == EvTick) r.unx = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: every accepted word against the oldest prediction.
  always @(posedge clk_i) begin
    outcome_t w;
    logic [OutDataBits-1:0] d;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      d = m_axis_tdata_o;
      if (pending_outcomes.size() == 0) begin
        $error("result word 0x%014h arrived with no event outstanding", d);
        fail_count++;
      end else begin
        w = pending_outcomes.pop_front();
        results_checked++;
        check_field("new_state", 16'(w.st), 16'(d[3:0]));
        check_field("send_kind", 16'(w.send), 16'(d[6:4]));
        check_field("send_expires", w.sexp, d[22:7]);
        check_field("timer_cmd", 16'(w.tcmd), 16'(d[24:23]));
        check_field("timer_value", w.tval, d[40:25]);
        check_field("dialog_cmd", 16'(w.dlg), 16'(d[43:41]));
        check_field("notify_cmd", 16'(w.ntf), 16'(d[46:44]));
        check_field("release_response_ref", 16'(w.rel), 16'(d[47]));
        check_field("free_object", 16'(w.fre), 16'(d[48]));
        check_field("error_notice", 16'(w.err), 16'(d[49]));
        check_field("unexpected_event", 16'(w.unx), 16'(d[50]));
        check_field("padding", 16'h0, 16'(d[55:51]));
      end
    end
  end

  // Offer one event word, wait for the handshake and record its prediction.
  // Valid stays high afterwards so back-to-back words need no toggling.
  task automatic send_event(event_e ev, logic [15:0] expires, logic contact,
                            logic term, logic fails, int gap);
    outcome_t r;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= ev;
    s_axis_tdata_i <= {5'b0, fails, term, contact, expires};
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = predict_transition(ev, expires, contact, term, fails);
    sub_state_q = r.st;
    state_seen[r.st] = 1'b1;
    pending_outcomes.push_back(r);
    events_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering words and wait until every predicted result has come back.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_transfer(input logic wr, input cfg_idx_e idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic read_register(cfg_idx_e idx, logic [15:0] want);
    logic [31:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== {16'h0, want}) begin
      $error("register %s: expected 0x%08h, read 0x%08h", idx.name(), {16'h0, want}, rd);
      fail_count++;
    end
  endtask

  // Upper data bits are junk: only the low 16 bits may land in the register.
  task automatic write_register(cfg_idx_e idx, logic [15:0] value);
    logic [31:0] rd;
    apb_transfer(1'b1, idx, {16'($urandom_range(0, 65535)), value}, rd);
    case (idx)
      CfgRefreshMargin: margin_q = value;
      CfgMinRefresh:    min_refresh_q = value;
      CfgRetryAfterErr: retry_q = value;
      CfgTermWait:      term_wait_q = value;
      default:          sub_length_q = value;
    endcase
    register_writes++;
    read_register(idx, value);
  endtask

  task automatic configure(logic [15:0] margin, logic [15:0] min_refresh,
                           logic [15:0] retry, logic [15:0] term_wait,
                           logic [15:0] sub_length);
    settle();
    write_register(CfgRefreshMargin, margin);
    write_register(CfgMinRefresh, min_refresh);
    write_register(CfgRetryAfterErr, retry);
    write_register(CfgTermWait, term_wait);
    write_register(CfgSubLength, sub_length);
  endtask

  // Events that make sense in a state, so the walk gets past the first states.
  function automatic event_e plausible_event(state_code_e s);
    event_e opts[$];
    case (s)
      CodeDestroyed:                     opts = '{EvStart};
      CodeUnconf, CodeResub:
        opts = '{EvNotify, Ev1xx, Ev2xx, Ev2xx, Ev3xx, Ev4xx, EvTick, EvDestroy};
      CodeUnconfDestroy, CodeResubDestroy:
        opts = '{EvNotify, Ev2xx, Ev2xx, Ev3xx, Ev4xx, EvTick};
      CodeConfirmed:                     opts = '{EvNotify, EvTick, EvTick, EvDestroy};
      CodeWaiting:                       opts = '{EvTick, EvTick, EvDestroy};
      CodeWaitTerm:                      opts = '{EvNotify, EvTick};
      default:                           opts = '{EvNotify, Ev2xx, Ev2xx, Ev3xx, Ev4xx};
    endcase
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  // Expiry values lean toward the clamp boundary and the extremes.
  function automatic logic [15:0] pick_expiry();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 100));
      3:       return margin_q + min_refresh_q + 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_events(int count, bit no_gaps);
    event_e ev;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) begin
        src_idle_on = ($urandom_range(0, 2) != 0);
        sink_idle_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 3) != 0) ev = plausible_event(sub_state_q);
      else ev = event_e'($urandom_range(0, 7));
      send_event(ev, pick_expiry(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 4) == 0), no_gaps ? 0 : pick_gap(src_idle_on));
    end
  endtask

  task automatic test_register_defaults();
    read_register(CfgRefreshMargin, 16'd30);
    read_register(CfgMinRefresh, 16'd30);
    read_register(CfgRetryAfterErr, 16'd120);
    read_register(CfgTermWait, 16'd30);
    read_register(CfgSubLength, 16'd3600);
  endtask

  // Walk through every event and the corner cases with the reset timings.
  task automatic test_directed_events();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    // Destroyed state rejects everything but a start.
    send_event(EvTick, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev1xx, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(EvNotify, 16'hFFFF, 1, 1, 1, pick_gap(1));
    send_event(Ev2xx, 16'hFFFF, 0, 0, 0, pick_gap(1));
    send_event(EvDestroy, 16'h0, 0, 0, 0, pick_gap(1));
    // Failed first SUBSCRIBE, then a NOTIFY and a response out of order.
    send_event(EvStart, 16'h0, 0, 0, 1, pick_gap(1));
    send_event(EvNotify, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev4xx, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(EvTick, 16'h0, 0, 0, 0, pick_gap(1));
    // Start while active, and a failure flag on an event that sends nothing.
    send_event(EvStart, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(EvNotify, 16'h0, 0, 0, 1, pick_gap(1));
    // A zero expiry clamps to the minimum refresh time.
    send_event(Ev2xx, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev1xx, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(EvTick, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev2xx, 16'hFFFF, 0, 0, 0, pick_gap(1));
    // Orderly unsubscribe ending in a terminating NOTIFY.
    send_event(EvDestroy, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev2xx, 16'd77, 0, 0, 0, pick_gap(1));
    send_event(EvNotify, 16'h0, 0, 1, 0, pick_gap(1));
    // Redirect with a contact, destroy before the 2xx, failed unsubscribe.
    send_event(EvStart, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev3xx, 16'h0, 1, 0, 0, pick_gap(1));
    send_event(EvDestroy, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev2xx, 16'd500, 0, 0, 1, pick_gap(1));
    // Redirect without a contact, then give up while waiting.
    send_event(EvStart, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(Ev3xx, 16'h0, 0, 0, 0, pick_gap(1));
    send_event(EvDestroy, 16'h0, 0, 0, 0, pick_gap(1));
    settle();
  endtask

  // The result side holds off while events keep coming, so the block fills up.
  task automatic test_output_backpressure();
    sink_idle_on = 1'b0;
    hold_request = 80;
    send_random_events(16, 1'b1);
    settle();
  endtask

  // Bursts separated by full drains of the result side.
  task automatic test_drain_pause();
    for (int b = 0; b < 4; b++) begin
      send_random_events(5, 1'b1);
      settle();
    end
  endtask

  // Random traffic under reset, minimum, maximum, mixed and random timings.
  task automatic test_register_sweep();
    send_random_events(240, 1'b0);
    configure(16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_random_events(240, 1'b0);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random_events(240, 1'b0);
    configure(16'hFFFF, 16'h0, 16'd1, 16'hFFFE, 16'd1);
    send_random_events(240, 1'b0);
    configure(16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
    send_random_events(240, 1'b0);
    settle();
  endtask

  initial begin
    int states_reached;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = EvNotify;
    m_axis_tready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sub_state_q = CodeDestroyed;
    margin_q = 16'd30;
    min_refresh_q = 16'd30;
    retry_q = 16'd120;
    term_wait_q = 16'd30;
    sub_length_q = 16'd3600;
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_stall = 0;
    sink_hold = 0;
    hold_request = 0;
    fail_count = 0;
    events_sent = 0;
    results_checked = 0;
    register_writes = 0;
    cycle_count = 0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_register_defaults();
    test_directed_events();
    test_output_backpressure();
    test_drain_pause();
    test_register_sweep();

    settle();
    repeat (DrainCycles) @(posedge clk_i);

    states_reached = 0;
    foreach (state_seen[i]) states_reached += state_seen[i];
    $display("Sent %0d events and checked %0d results, reaching %0d of 9 states.",
             events_sent, results_checked, states_reached);
    $display("Made %0d register writes across five timing settings; %0d mismatches.",
             register_writes, fail_count);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/ssc_pkg.sv
design/ssc_cfg_regs.sv
design/ssc_next.sv
design/sip_subscription_client_fsm_top.sv
tb/tb_top.sv
